/* hdl/spi_companion_slave_responder_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef SPI_COMPANION_SLAVE_RESPONDER_CORE_ASSERT_SVH
`define SPI_COMPANION_SLAVE_RESPONDER_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define SCSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define SCSR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* hdl/scsr_pkg.sv */
`timescale 1ns / 1ps
package scsr_pkg;

    localparam int CHANNEL_BYTES  = 32;
    localparam int RESPONSE_START = 16;

    localparam int CH_WORDS    = CHANNEL_BYTES / 2;
    localparam int CH_AW       = (CH_WORDS > 1) ? $clog2(CH_WORDS) : 1;
    localparam int FETCH_LIMIT = CH_WORDS * 2;

    localparam int HDR_BYTES = 8;
    localparam int SETUP_LEN = 6;

    localparam logic [7:0] FRAME_END = 8'hFF;
    localparam logic [7:0] TX_ZERO   = 8'h00;

    localparam logic [7:0] CMD_SETUP = 8'd1;
    localparam logic [7:0] CMD_FETCH = 8'd2;
    localparam logic [7:0] CMD_END   = 8'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    // Input word layout.
    localparam int IN_RX_POS   = 0;
    localparam int IN_CH_POS   = 8;
    localparam int IN_VAL_POS  = 16;
    localparam int IN_IDLE_POS = 32;
    localparam int IN_W        = 40;

    // Result word layout.
    localparam int OUT_TX_POS     = 0;
    localparam int OUT_CMD_POS    = 8;
    localparam int OUT_FSTATE_POS = 16;
    localparam int OUT_TICK_POS   = 24;
    localparam int OUT_SERIAL_POS = 40;
    localparam int OUT_FLIGHT_POS = 56;
    localparam int OUT_CONN_POS   = 72;
    localparam int OUT_ACC_POS    = 73;
    localparam int OUT_W          = 80;

    typedef enum logic [1:0] {
        TX_KEEP  = 2'd0,
        TX_CONST = 2'd1,
        TX_MEM   = 2'd2
    } tx_mode_t;

    function automatic logic [7:0] setup_byte(input logic [15:0] node_id,
                                              input logic [7:0]  period,
                                              input logic [4:0]  count,
                                              input logic [2:0]  k);
        logic [7:0] b;
        case (k)
            3'd0:    b = node_id[7:0];
            3'd1:    b = node_id[15:8];
            3'd2:    b = ~node_id[7:0];
            3'd3:    b = ~node_id[15:8];
            3'd4:    b = period;
            3'd5:    b = {3'b000, count};
            default: b = TX_ZERO;
        endcase
        return b;
    endfunction

endpackage

/* hdl/spi_companion_slave_responder_core.sv */
// SPI companion-link slave responder. Each input word is either one received SPI
// byte (tuser 0) or a channel value update (tuser 1); each produces exactly one
// result word with the byte loaded for the next transfer and the captured frame
// header. The block accepts one word per clock cycle unless the output is held;
// each result passes the p1 stage and the output register. The channel table is
// a one-port-write, one-port-read RAM of 16-bit entries with a registered read,
// and per-entry valid bits make entries read as zero after reset without a clearing
// pass. The user writes configuration only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
module spi_companion_slave_responder_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [scsr_pkg::IN_W-1:0]       s_tdata,   // rx_byte, channel_index,
                                                       // channel_value, bus_idle
    input  logic                            s_tuser,   // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [scsr_pkg::OUT_W-1:0]      m_tdata,   // tx_byte, command, mission_phase,
                                                       // tick, serial_number,
                                                       // flight_number, connected,
                                                       // update_accepted
    input  logic                            cfg_we,
    input  logic [scsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import scsr_pkg::*;

    logic [15:0] node_id_reg;
    logic [7:0]  period_reg;
    logic [4:0]  count_reg;

    logic [7:0] header_reg [HDR_BYTES];
    logic [7:0] frame_reg, frame_next;
    logic [2:0] setup_reg, setup_next;
    logic [7:0] fetch_reg, fetch_next;
    logic [7:0] tx_reg;
    logic [CH_WORDS-1:0] valid_reg;

    logic             p1_valid_reg;
    tx_mode_t         p1_mode_reg, p1_mode_next;
    logic [7:0]       p1_const_reg, p1_const_next;
    logic             p1_hi_reg;
    logic [CH_AW-1:0] p1_addr_reg;
    logic             p1_acc_reg, p1_acc_next;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic        s_accept, m_free, advance;
    logic [7:0]  rx_byte, ch_index;
    logic [15:0] ch_value;
    logic        bus_idle;
    logic        hdr_we;
    logic [7:0]  cmd;
    logic [7:0]  frame_inc, fetch_inc;
    logic [2:0]  setup_inc;
    logic        respond;
    logic        upd_ok;

    logic             ram_we;
    logic [CH_AW-1:0] ram_raddr;
    logic [15:0]      ram_rdata;
    logic [7:0]       tx_res;
    logic [OUT_W-1:0] out_word;

    assign rx_byte  = s_tdata[IN_RX_POS +: 8];
    assign ch_index = s_tdata[IN_CH_POS +: 8];
    assign ch_value = s_tdata[IN_VAL_POS +: 16];
    assign bus_idle = s_tdata[IN_IDLE_POS];

    assign m_free   = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || m_free;
    assign s_accept = s_tvalid && s_tready;
    assign advance  = p1_valid_reg && m_free;

    assign hdr_we    = (frame_reg[7:3] == 5'd0);
    assign cmd       = (frame_reg == 8'd0) ? rx_byte : header_reg[0];
    assign frame_inc = frame_reg + 8'd1;
    assign setup_inc = setup_reg + 3'd1;
    assign fetch_inc = fetch_reg + 8'd1;
    assign respond   = ({1'b0, frame_inc} >= 9'(RESPONSE_START));

    assign upd_ok = bus_idle && (ch_index < {3'b000, count_reg})
                    && ({1'b0, ch_index} < 9'(CH_WORDS));
    assign ram_we = s_accept && s_tuser && upd_ok;

    assign ram_raddr = s_accept ? fetch_reg[CH_AW:1] : p1_addr_reg;

    scsr_ram #(
        .WIDTH (16),
        .DEPTH (CH_WORDS)
    ) u_chan_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ch_index[CH_AW-1:0]),
        .wdata (ch_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        frame_next    = frame_reg;
        setup_next    = setup_reg;
        fetch_next    = fetch_reg;
        p1_mode_next  = TX_KEEP;
        p1_const_next = TX_ZERO;
        p1_acc_next   = 1'b0;
        if (s_tuser) begin
            p1_acc_next = upd_ok;
        end else begin
            frame_next   = frame_inc;
            p1_mode_next = TX_CONST;
            if (cmd == CMD_SETUP && respond) begin
                p1_const_next = setup_byte(node_id_reg, period_reg, count_reg, setup_reg);
                setup_next    = setup_inc;
                if ({1'b0, setup_inc} >= 4'(SETUP_LEN)) begin
                    setup_next = 3'd0;
                    frame_next = FRAME_END;
                end
            end else if (cmd == CMD_FETCH && respond) begin
                if ({1'b0, fetch_reg} < 9'(FETCH_LIMIT)) begin
                    p1_mode_next = TX_MEM;
                end
                fetch_next = fetch_inc;
                if (fetch_inc >= {2'b00, count_reg, 1'b0}) begin
                    fetch_next = 8'd0;
                    frame_next = FRAME_END;
                end
            end else if (cmd == CMD_END && respond) begin
                frame_next = FRAME_END;
            end
        end
    end

    always_comb begin
        case (p1_mode_reg)
            TX_CONST: tx_res = p1_const_reg;
            TX_MEM:   tx_res = valid_reg[p1_addr_reg]
                               ? (p1_hi_reg ? ram_rdata[15:8] : ram_rdata[7:0]) : TX_ZERO;
            default:  tx_res = tx_reg;
        endcase
    end

    always_comb begin
        out_word = '0;
        out_word[OUT_TX_POS +: 8]      = tx_res;
        out_word[OUT_CMD_POS +: 8]     = header_reg[0];
        out_word[OUT_FSTATE_POS +: 8]  = header_reg[1];
        out_word[OUT_TICK_POS +: 16]   = {header_reg[3], header_reg[2]};
        out_word[OUT_SERIAL_POS +: 16] = {header_reg[5], header_reg[4]};
        out_word[OUT_FLIGHT_POS +: 16] = {header_reg[7], header_reg[6]};
        out_word[OUT_CONN_POS]         = (header_reg[0] > 8'd1);
        out_word[OUT_ACC_POS]          = p1_acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg  <= 16'd0;
            period_reg   <= 8'd0;
            count_reg    <= 5'd1;
            frame_reg    <= 8'd0;
            setup_reg    <= 3'd0;
            fetch_reg    <= 8'd0;
            tx_reg       <= TX_ZERO;
            valid_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < HDR_BYTES; i++) begin
                header_reg[i] <= 8'd0;
            end
        end else begin
            if (s_accept) begin
                frame_reg <= frame_next;
                setup_reg <= setup_next;
                fetch_reg <= fetch_next;
                if (!s_tuser && hdr_we) begin
                    header_reg[frame_reg[2:0]] <= rx_byte;
                end
                if (ram_we) begin
                    valid_reg[ch_index[CH_AW-1:0]] <= 1'b1;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_NODE_ID: begin
                        node_id_reg <= cfg_wdata;
                        frame_reg   <= 8'd0;
                        setup_reg   <= 3'd0;
                        fetch_reg   <= 8'd0;
                    end
                    REG_UPDATE_PERIOD: begin
                        period_reg <= cfg_wdata[7:0];
                        frame_reg  <= 8'd0;
                        setup_reg  <= 3'd0;
                        fetch_reg  <= 8'd0;
                    end
                    REG_CHANNEL_COUNT: begin
                        count_reg <= cfg_wdata[4:0];
                        frame_reg <= 8'd0;
                        setup_reg <= 3'd0;
                        fetch_reg <= 8'd0;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (advance) begin
                p1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                tx_reg      <= tx_res;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_mode_reg  <= p1_mode_next;
            p1_const_reg <= p1_const_next;
            p1_hi_reg    <= fetch_reg[0];
            p1_addr_reg  <= fetch_reg[CH_AW:1];
            p1_acc_reg   <= p1_acc_next;
        end
        if (advance) begin
            m_data_reg <= out_word;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* hdl/scsr_ram.sv */
`timescale 1ns / 1ps
module scsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/scsr_checker.sv */
`timescale 1ns / 1ps
`include "spi_companion_slave_responder_core_assert.svh"
module scsr_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [scsr_pkg::OUT_W-1:0] m_tdata
);
    import scsr_pkg::*;

    logic out_stall;
    logic conn_ok;

    assign out_stall = m_tvalid && !m_tready;
    assign conn_ok   = (m_tdata[OUT_CONN_POS] == (m_tdata[OUT_CMD_POS +: 8] > 8'd1));

    `SCSR_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(m_tdata), "held result changed")
    `SCSR_ASSERT(a_in_stall, !s_tready |-> out_stall, "input stalled while output can move")
    `SCSR_ASSERT(a_connected, m_tvalid |-> conn_ok, "connected flag disagrees with command")
    `SCSR_ASSERT_RST(a_reset, !aresetn |=> !m_tvalid && s_tready, "not empty after reset")

endmodule

bind spi_companion_slave_responder_core scsr_checker u_scsr_checker (.*);

/* tb/spi_companion_slave_responder_core_tb.sv */
`timescale 1ns / 1ps
module spi_companion_slave_responder_core_tb;
    import scsr_pkg::*;

    localparam int TB_AW = $clog2(CHANNEL_BYTES);

    typedef struct packed {
        logic        func;
        logic [7:0]  rx;
        logic [7:0]  chan;
        logic [15:0] value;
        logic        idle;
    } link_word_t;

    typedef struct packed {
        logic [7:0]  tx;
        logic [7:0]  command;
        logic [7:0]  fstate;
        logic [15:0] tick;
        logic [15:0] serial;
        logic [15:0] flight;
        logic        connected;
        logic        accepted;
    } reply_t;

    typedef struct {
        logic [7:0]  header[HDR_BYTES];
        logic [7:0]  frame_pos;
        logic [2:0]  setup_pos;
        logic [7:0]  fetch_pos;
        logic [7:0]  table_bytes[CHANNEL_BYTES];
        logic [7:0]  tx;
        logic [15:0] node_id;
        logic [7:0]  period;
        logic [4:0]  count;
    } responder_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    link_word_t words_to_send[$];
    reply_t     replies_due[$];
    link_word_t word_on_bus;
    responder_t bus_side;
    responder_t source_side;
    bit         steady_traffic = 1'b0;
    int         failures = 0;
    int         replies_seen = 0;
    int         hold_left = 0;
    bit         hold_armed = 1'b1;

    spi_companion_slave_responder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic responder_t responder_at_reset();
        responder_t st;
        for (int i = 0; i < HDR_BYTES; i++) st.header[i] = 8'h00;
        for (int i = 0; i < CHANNEL_BYTES; i++) st.table_bytes[i] = 8'h00;
        st.frame_pos = 8'h00;
        st.setup_pos = 3'd0;
        st.fetch_pos = 8'h00;
        st.tx        = TX_ZERO;
        st.node_id   = 16'h0000;
        st.period    = 8'h00;
        st.count     = 5'd1;
        return st;
    endfunction

    function automatic void apply_register(inout responder_t st,
                                           input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_NODE_ID:       st.node_id = data;
            REG_UPDATE_PERIOD: st.period = data[7:0];
            REG_CHANNEL_COUNT: st.count = data[4:0];
            default:           return;
        endcase
        st.frame_pos = 8'h00;
        st.setup_pos = 3'd0;
        st.fetch_pos = 8'h00;
    endfunction

    function automatic reply_t responder_step(inout responder_t st, input link_word_t w);
        reply_t           r;
        logic [15:0]      inverse;
        logic             answering;
        int               total;
        logic [TB_AW-1:0] slot_lo;
        logic [TB_AW-1:0] slot_hi;
        r = '0;
        if (!w.func) begin
            if (st.frame_pos < HDR_BYTES) st.header[st.frame_pos[2:0]] = w.rx;
            st.frame_pos = st.frame_pos + 8'd1;
            answering = (st.frame_pos >= RESPONSE_START);
            if (answering && st.header[0] == CMD_SETUP) begin
                inverse = ~st.node_id;
                case (st.setup_pos)
                    3'd0:    st.tx = st.node_id[7:0];
                    3'd1:    st.tx = st.node_id[15:8];
                    3'd2:    st.tx = inverse[7:0];
                    3'd3:    st.tx = inverse[15:8];
                    3'd4:    st.tx = st.period;
                    3'd5:    st.tx = {3'b000, st.count};
                    default: st.tx = TX_ZERO;
                endcase
                st.setup_pos = st.setup_pos + 3'd1;
                if (st.setup_pos >= SETUP_LEN) begin
                    st.setup_pos = 3'd0;
                    st.frame_pos = FRAME_END;
                end
            end else if (answering && st.header[0] == CMD_FETCH) begin
                total = 2 * int'(st.count);
                st.tx = (int'(st.fetch_pos) < CHANNEL_BYTES) ?
                        st.table_bytes[st.fetch_pos[TB_AW-1:0]] : TX_ZERO;
                st.fetch_pos = st.fetch_pos + 8'd1;
                if (int'(st.fetch_pos) >= total) begin
                    st.fetch_pos = 8'h00;
                    st.frame_pos = FRAME_END;
                end
            end else if (answering && st.header[0] == CMD_END) begin
                st.frame_pos = FRAME_END;
                st.tx = TX_ZERO;
            end else begin
                st.tx = TX_ZERO;
            end
        end else if (w.idle && w.chan < st.count && 2 * int'(w.chan) + 1 < CHANNEL_BYTES) begin
            slot_lo = TB_AW'(2 * int'(w.chan));
            slot_hi = slot_lo + TB_AW'(1);
            st.table_bytes[slot_lo] = w.value[7:0];
            st.table_bytes[slot_hi] = w.value[15:8];
            r.accepted = 1'b1;
        end
        r.tx        = st.tx;
        r.command   = st.header[0];
        r.fstate    = st.header[1];
        r.tick      = {st.header[3], st.header[2]};
        r.serial    = {st.header[5], st.header[4]};
        r.flight    = {st.header[7], st.header[6]};
        r.connected = (st.header[0] > CMD_SETUP);
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_word(link_word_t w);
        logic [IN_W-1:0] d;
        d = '0;
        d[IN_RX_POS +: 8]   = w.rx;
        d[IN_CH_POS +: 8]   = w.chan;
        d[IN_VAL_POS +: 16] = w.value;
        d[IN_IDLE_POS]      = w.idle;
        return d;
    endfunction

    task automatic queue_word(input link_word_t w);
        void'(responder_step(source_side, w));
        words_to_send.push_back(w);
    endtask

    task automatic queue_spi(input logic [7:0] rx);
        link_word_t w;
        w.func  = 1'b0;
        w.rx    = rx;
        w.chan  = 8'($urandom_range(0, 255));
        w.value = 16'($urandom_range(0, 65535));
        w.idle  = 1'($urandom_range(0, 1));
        queue_word(w);
    endtask

    task automatic queue_update(input logic [7:0] chan, input logic [15:0] value,
                                input logic idle);
        link_word_t w;
        w.func  = 1'b1;
        w.rx    = 8'($urandom_range(0, 255));
        w.chan  = chan;
        w.value = value;
        w.idle  = idle;
        queue_word(w);
    endtask

    task automatic queue_random_update();
        int kind;
        int top;
        kind = $urandom_range(0, 9);
        top  = (source_side.count == 5'd0) ? 0 : int'(source_side.count) - 1;
        if (kind < 6) begin
            queue_update(8'($urandom_range(0, top)), 16'($urandom_range(0, 65535)), 1'b1);
        end else if (kind < 8) begin
            queue_update(8'($urandom_range(0, top)), 16'($urandom_range(0, 65535)), 1'b0);
        end else begin
            queue_update(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    // Frames are built from the frame position the block will have reached, so
    // most traffic is complete header and reply sequences with random content.
    task automatic queue_traffic(input int n, input bit odd_command);
        logic [7:0] b;
        int         pick;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                queue_random_update();
            end else begin
                b = 8'($urandom_range(0, 255));
                if (source_side.frame_pos == 8'h00) begin
                    pick = $urandom_range(0, 99);
                    if (odd_command) begin
                        b = 8'($urandom_range(4, 255));
                        odd_command = 1'b0;
                    end else if (pick < 35) begin
                        b = CMD_SETUP;
                    end else if (pick < 70) begin
                        b = CMD_FETCH;
                    end else if (pick < 97) begin
                        b = CMD_END;
                    end
                end
                queue_spi(b);
            end
        end
    endtask

    task automatic wait_until_quiet();
        while (words_to_send.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        apply_register(bus_side, idx, data);
        apply_register(source_side, idx, data);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] board, input logic [7:0] period,
                             input logic [4:0] count);
        wait_until_quiet();
        write_register(REG_NODE_ID, board);
        write_register(REG_UPDATE_PERIOD, {8'h00, period});
        write_register(REG_CHANNEL_COUNT, {11'b0, count});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                replies_due.push_back(responder_step(bus_side, word_on_bus));
            if (!s_tvalid || s_tready) begin
                if (words_to_send.size() != 0 &&
                    (steady_traffic || $urandom_range(0, 99) >= 17)) begin
                    word_on_bus = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_word(word_on_bus);
                    s_tuser  <= word_on_bus.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The receiver stops once for a long stretch so that the input side backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_armed && replies_seen >= 400) begin
            hold_left  <= 150;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && (steady_traffic || $urandom_range(0, 99) >= 17);
    end

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.tx        = m_tdata[OUT_TX_POS +: 8];
            got.command   = m_tdata[OUT_CMD_POS +: 8];
            got.fstate    = m_tdata[OUT_FSTATE_POS +: 8];
            got.tick      = m_tdata[OUT_TICK_POS +: 16];
            got.serial    = m_tdata[OUT_SERIAL_POS +: 16];
            got.flight    = m_tdata[OUT_FLIGHT_POS +: 16];
            got.connected = m_tdata[OUT_CONN_POS];
            got.accepted  = m_tdata[OUT_ACC_POS];
            if (replies_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("word %0d: result with nothing outstanding, tdata=%h",
                             replies_seen, m_tdata);
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("word %0d exp: tx=%h cmd=%h fs=%h tk=%h sn=%h fn=%h c=%b a=%b",
                                 replies_seen, want.tx, want.command, want.fstate, want.tick,
                                 want.serial, want.flight, want.connected, want.accepted);
                        $display("word %0d got: tx=%h cmd=%h fs=%h tk=%h sn=%h fn=%h c=%b a=%b",
                                 replies_seen, got.tx, got.command, got.fstate, got.tick,
                                 got.serial, got.flight, got.connected, got.accepted);
                    end
                end
            end
            replies_seen++;
        end
    end

    initial begin
        bus_side    = responder_at_reset();
        source_side = responder_at_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        queue_update(8'd0, 16'hFFFF, 1'b1);
        queue_update(8'd0, 16'h1234, 1'b0);
        queue_update(8'd255, 16'h0000, 1'b1);
        queue_update(8'd1, 16'hA5A5, 1'b1);
        queue_spi(CMD_SETUP);
        for (int k = 1; k < 22; k++)
            queue_spi((k % 2) ? 8'hFF : 8'h00);

        configure(16'hFFFF, 8'hFF, 5'd16);
        queue_traffic(320, 1'b1);

        configure(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 5'd31);
        steady_traffic = 1'b1;
        queue_traffic(150, 1'b0);
        wait_until_quiet();
        steady_traffic = 1'b0;

        configure(16'h0000, 8'h00, 5'd0);
        queue_traffic(120, 1'b0);

        for (int p = 0; p < 3; p++) begin
            configure(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      5'($urandom_range(1, 16)));
            queue_traffic(110, 1'b0);
        end

        wait_until_quiet();
        repeat (20) @(posedge aclk);
        if (failures == 0 && replies_due.size() == 0)
            $display("spi_companion_slave_responder_core: match");
        else
            $display("spi_companion_slave_responder_core: mismatch");
        $finish;
    end

    initial begin
        #1000000;
        $display("spi_companion_slave_responder_core: mismatch");
        $finish;
    end

endmodule
